// ----- rtl/plm_pkg.sv -----
// package for the packet loss monitor: widths, register indexes, fsm states
// and the controller/datapath command and status structs. no dependencies.
`timescale 1ns / 1ps
package plm_pkg;

  localparam int CNT_W = 32;
  localparam int SEQ_W = 64;
  localparam int TIME_W = 64;
  localparam int DIV_STEPS = 64;
  localparam int STEP_W = 6;

  localparam logic [31:0] BAD_SECONDS = 32'hFFFF_FFFF;
  localparam logic [63:0] ROUND_HALF = 64'd512;
  localparam int TICK_SHIFT = 10;

  localparam logic [31:0] CLK_TICKS_RST = 32'd200000000;
  localparam logic [7:0] FRAME_RST = 8'd16;
  localparam logic [31:0] WINDOW_RST = 32'd10000;

  typedef enum logic [1:0] {
    REG_CLOCK_TICKS = 2'd0,
    REG_FRAME_SAMPLES = 2'd1,
    REG_KEEP_LOWEST = 2'd2,
    REG_ORDER_WINDOW = 2'd3
  } reg_idx_t;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_TIME,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic report;
    logic mult;
    logic time_calc;
    logic div_start;
    logic div_step;
    logic finish;
  } plm_cmd_t;

  typedef struct packed {
    logic is_report;
    logic div_needed;
    logic div_last;
  } plm_stat_t;

endpackage

// ----- rtl/plm_ctrl.sv -----
// controller fsm for the packet loss monitor
// depends on plm_pkg; drives commands to plm_datapath
`timescale 1ns / 1ps
module plm_ctrl
  import plm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      out_busy,
  input  plm_stat_t stat,
  output plm_cmd_t  cmd,
  output logic      busy
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_MULT;
      end
      ST_MULT: begin
        if (stat.is_report) state_next = ST_DONE;
        else state_next = ST_TIME;
      end
      ST_TIME: begin
        if (stat.div_needed) state_next = ST_DIV;
        else state_next = ST_DONE;
      end
      ST_DIV: begin
        if (stat.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = in_fire;
      end
      ST_MULT: begin
        cmd.report = stat.is_report;
        cmd.mult = !stat.is_report;
      end
      ST_TIME: begin
        cmd.time_calc = 1'b1;
        cmd.div_start = stat.div_needed;
      end
      ST_DIV: cmd.div_step = 1'b1;
      ST_DONE: cmd.finish = !out_busy;
      default: busy = 1'b1;
    endcase
  end

  // at most one command a cycle, apart from div_start, which comes with time_calc
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.report, cmd.mult, cmd.time_calc, cmd.div_step, cmd.finish}))
    else $error("plm_ctrl: overlapping commands");
  // an accepted item always starts work next cycle
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> state == ST_MULT)
    else $error("plm_ctrl: load did not start work");
  // divide runs only after the time step
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> ($past(state) == ST_TIME || $past(state) == ST_DIV))
    else $error("plm_ctrl: divide entered out of order");

endmodule

// ----- rtl/plm_datapath.sv -----
// datapath: counters, time conversion, serial divider, sequence tracking
// depends on plm_pkg; controlled by plm_ctrl
`timescale 1ns / 1ps
module plm_datapath
  import plm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  plm_cmd_t          cmd,
  output plm_stat_t         stat,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [31:0]       cfg_data,
  input  logic              in_op,
  input  logic [SEQ_W-1:0]  in_seq,
  input  logic [31:0]       in_secs,
  input  logic [31:0]       in_frac,
  input  logic              in_stall,
  output logic              r_is_report,
  output logic [CNT_W-1:0]  r_packet,
  output logic [CNT_W-1:0]  r_missed,
  output logic [CNT_W-1:0]  r_reorder,
  output logic [CNT_W-1:0]  r_bad,
  output logic              r_starve_valid,
  output logic [SEQ_W-1:0]  r_starve_seq
);

  logic [31:0] clock_ticks;
  logic [7:0] frame_samples;
  logic keep_lowest;
  logic [31:0] order_window;

  logic [CNT_W-1:0] packet_count, missed_count, reorder_count, bad_count;
  logic [TIME_W-1:0] next_time;
  logic [SEQ_W-1:0] tracked_seq;

  logic op_q, stall_q;
  logic [SEQ_W-1:0] seq_q;
  logic [31:0] secs_q, frac_q;
  logic [63:0] product;

  logic [63:0] div_rem_num;
  logic [7:0] div_rem;
  logic [63:0] div_quo;
  logic [STEP_W-1:0] div_cnt;
  logic div_quo_valid;

  logic [TIME_W-1:0] t_calc;
  logic [8:0] rem_shift;
  logic [SEQ_W-1:0] track_next;
  logic [SEQ_W-1:0] d_up, d_dn;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ticks <= CLK_TICKS_RST;
      frame_samples <= FRAME_RST;
      keep_lowest <= 1'b0;
      order_window <= WINDOW_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_CLOCK_TICKS: clock_ticks <= cfg_data;
        REG_FRAME_SAMPLES: frame_samples <= cfg_data[7:0];
        REG_KEEP_LOWEST: keep_lowest <= cfg_data[0];
        REG_ORDER_WINDOW: order_window <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample time from the registered product
  assign t_calc = ((product + ROUND_HALF) >> TICK_SHIFT) + {32'd0, frac_q};

  // one restoring divide step
  assign rem_shift = {div_rem, div_rem_num[63]};

  // sequence tracking with wrap window
  assign d_up = seq_q - tracked_seq;
  assign d_dn = tracked_seq - seq_q;
  always_comb begin
    track_next = tracked_seq;
    if (tracked_seq == '0) begin
      track_next = seq_q;
    end else if (keep_lowest) begin
      if (seq_q < tracked_seq && d_dn < {32'd0, order_window}) track_next = seq_q;
    end else if (seq_q > tracked_seq) begin
      if (d_up < {32'd0, order_window}) track_next = seq_q;
    end else if (seq_q < tracked_seq) begin
      if (d_dn > {32'd0, order_window}) track_next = seq_q;
    end
  end

  assign stat.is_report = op_q;
  assign stat.div_needed = (t_calc != next_time) && (next_time != '0)
                           && (frame_samples != 8'd0) && (secs_q != BAD_SECONDS);
  assign stat.div_last = (div_cnt == STEP_W'(DIV_STEPS - 1));

  // input capture, multiply and divide
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= in_op;
      seq_q <= in_seq;
      secs_q <= in_secs;
      frac_q <= in_frac;
      stall_q <= in_stall;
    end
    if (cmd.mult) product <= 64'(secs_q) * 64'(clock_ticks);
    if (cmd.div_start) begin
      div_rem_num <= t_calc - next_time;
      div_rem <= '0;
      div_quo <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem_num <= {div_rem_num[62:0], 1'b0};
      if (rem_shift >= {1'b0, frame_samples}) begin
        div_rem <= 8'(rem_shift - {1'b0, frame_samples});
        div_quo <= {div_quo[62:0], 1'b1};
      end else begin
        div_rem <= rem_shift[7:0];
        div_quo <= {div_quo[62:0], 1'b0};
      end
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_count <= '0;
      missed_count <= '0;
      reorder_count <= '0;
      bad_count <= '0;
      next_time <= '0;
      tracked_seq <= '0;
    end else if (cmd.report) begin
      r_is_report <= 1'b1;
      r_packet <= packet_count;
      r_missed <= missed_count;
      r_reorder <= reorder_count;
      r_bad <= bad_count;
      r_starve_valid <= 1'b0;
      r_starve_seq <= '0;
      packet_count <= '0;
      missed_count <= '0;
      reorder_count <= '0;
      bad_count <= '0;
    end else if (cmd.time_calc) begin
      r_is_report <= 1'b0;
      r_packet <= '0;
      r_missed <= '0;
      r_reorder <= '0;
      r_bad <= '0;
      packet_count <= packet_count + 1'b1;
      if (stall_q && tracked_seq != '0) begin
        r_starve_valid <= 1'b1;
        r_starve_seq <= tracked_seq;
      end else begin
        r_starve_valid <= 1'b0;
        r_starve_seq <= '0;
      end
      if (stall_q) tracked_seq <= '0;
      if (secs_q == BAD_SECONDS) begin
        bad_count <= bad_count + 1'b1;
      end else begin
        if (t_calc < next_time) reorder_count <= reorder_count + 1'b1;
        next_time <= t_calc + {56'd0, frame_samples};
      end
    end else if (cmd.finish && !op_q) begin
      tracked_seq <= track_next;
      if (div_quo_valid) missed_count <= missed_count + div_quo[CNT_W-1:0];
    end
  end

  // marks that a divide was started for this item
  always_ff @(posedge clk) begin
    if (rst || cmd.load) div_quo_valid <= 1'b0;
    else if (cmd.div_start) div_quo_valid <= 1'b1;
  end

  // counters clear after a report
  assert property (@(posedge clk) disable iff (rst) cmd.report |=> packet_count == '0)
    else $error("plm_datapath: counters not cleared by report");
  // a stall with a tracked value always reports it
  assert property (@(posedge clk) disable iff (rst)
    (cmd.time_calc && stall_q && tracked_seq != '0) |=> r_starve_valid)
    else $error("plm_datapath: stall did not report tracked sequence");
  // divider step counter restarts from zero at divide start
  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> div_cnt == '0)
    else $error("plm_datapath: divide counter not reset");

endmodule

// ----- rtl/packet_loss_monitor_top.sv -----
// Packet loss monitor. One item at a time: a packet header goes through
// load, a 32x32 multiply and a time compare, then a 64-step bit-serial
// divide by frame_samples when the stamp is valid, an expected time is set,
// the stamp differs from it and frame_samples is nonzero; a report goes
// through load, capture and finish. Results wait in the output register
// until taken; configuration must be written only while idle (not enforced).
// depends on plm_pkg, plm_ctrl, plm_datapath
`timescale 1ns / 1ps
module packet_loss_monitor_top
  import plm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  input  logic [SEQ_W-1:0]  seq_in,
  input  logic [31:0]       stamp_seconds,
  input  logic [31:0]       stamp_fraction,
  input  logic              read_stalled,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              is_report,
  output logic [CNT_W-1:0]  packet_total,
  output logic [CNT_W-1:0]  missed_total,
  output logic [CNT_W-1:0]  reorder_total,
  output logic [CNT_W-1:0]  bad_stamp_total,
  output logic              starve_valid,
  output logic [SEQ_W-1:0]  starve_seq
);

  plm_cmd_t cmd;
  plm_stat_t stat;
  logic busy;
  logic in_fire;
  logic [CNT_W-1:0] r_packet, r_missed, r_reorder, r_bad;
  logic r_is_report, r_starve_valid;
  logic [SEQ_W-1:0] r_starve_seq;

  // input transfer only while idle
  assign in_stall = busy;
  assign in_fire = in_valid && !busy;

  plm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(out_valid && out_stall),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  plm_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .in_op(operation), .in_seq(seq_in), .in_secs(stamp_seconds),
    .in_frac(stamp_fraction), .in_stall(read_stalled),
    .r_is_report(r_is_report), .r_packet(r_packet), .r_missed(r_missed),
    .r_reorder(r_reorder), .r_bad(r_bad), .r_starve_valid(r_starve_valid),
    .r_starve_seq(r_starve_seq)
  );

  // output register, loaded when the item finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.finish) out_valid <= 1'b1;
    end
    if (cmd.finish) begin
      is_report <= r_is_report;
      packet_total <= r_packet;
      missed_total <= r_missed;
      reorder_total <= r_reorder;
      bad_stamp_total <= r_bad;
      starve_valid <= r_starve_valid;
      starve_seq <= r_starve_seq;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for packet_loss_monitor_top: queued header driver,
// output monitor and a loss/reorder predictor. depends on plm_pkg and the rtl.
`timescale 1ns / 1ps
module tb_top;
  import plm_pkg::*;

  typedef struct {
    logic        op;
    logic [63:0] seq;
    logic [31:0] secs;
    logic [31:0] frac;
    logic        stl;
  } hdr_t;

  typedef struct {
    logic        rep;
    logic [31:0] pkts;
    logic [31:0] missed;
    logic [31:0] reord;
    logic [31:0] bad;
    logic        sv;
    logic [63:0] sseq;
  } stats_t;

  localparam int CYCLE_LIMIT = 900000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_CLOCK_TICKS;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = OP_PACKET;
  logic [63:0] seq_in = '0;
  logic [31:0] stamp_seconds = '0;
  logic [31:0] stamp_fraction = '0;
  logic read_stalled = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic is_report;
  logic [31:0] packet_total, missed_total, reorder_total, bad_stamp_total;
  logic starve_valid;
  logic [63:0] starve_seq;

  hdr_t pending_hdrs[$];
  stats_t expected_stats[$];
  int errors = 0;
  int cycles = 0;
  int hdrs_sent = 0;
  int stats_seen = 0;
  int reports_seen = 0;
  int hold_len = 0;

  // predictor state and configuration copy
  logic [31:0] m_ticks = CLK_TICKS_RST;
  logic [7:0]  m_frame = FRAME_RST;
  logic        m_low = 1'b0;
  logic [31:0] m_window = WINDOW_RST;
  logic [31:0] m_pkts = '0, m_missed = '0, m_reord = '0, m_bad = '0;
  logic [63:0] m_next = '0, m_track = '0;

  packet_loss_monitor_top u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // compute the result of one header and advance predictor state
  function automatic stats_t predict_stats(hdr_t h);
    stats_t r;
    logic [63:0] t, q;
    r = '{1'b0, '0, '0, '0, '0, 1'b0, '0};
    if (h.op == OP_REPORT) begin
      r.rep = 1'b1;
      r.pkts = m_pkts; r.missed = m_missed; r.reord = m_reord; r.bad = m_bad;
      m_pkts = '0; m_missed = '0; m_reord = '0; m_bad = '0;
      return r;
    end
    m_pkts = m_pkts + 1;
    if (h.stl && m_track != 0) begin
      r.sv = 1'b1;
      r.sseq = m_track;
      m_track = '0;
    end
    if (h.secs == BAD_SECONDS) begin
      m_bad = m_bad + 1;
    end else begin
      t = ((64'(h.secs) * 64'(m_ticks) + ROUND_HALF) >> TICK_SHIFT) + 64'(h.frac);
      if (m_next != t && m_next != 0 && m_frame != 0) begin
        q = (t - m_next) / 64'(m_frame);
        m_missed = m_missed + q[31:0];
      end
      if (t < m_next) m_reord = m_reord + 1;
      m_next = t + 64'(m_frame);
    end
    if (m_track == 0) begin
      m_track = h.seq;
    end else if (m_low) begin
      if (h.seq < m_track && (m_track - h.seq) < 64'(m_window)) m_track = h.seq;
    end else if (h.seq > m_track) begin
      if ((h.seq - m_track) < 64'(m_window)) m_track = h.seq;
    end else if (h.seq < m_track) begin
      if ((m_track - h.seq) > 64'(m_window)) m_track = h.seq;
    end
    return r;
  endfunction

  // sampled input handshake, taken at the rising edge
  logic in_take = 1'b0;
  always @(posedge clk) begin
    in_take <= in_valid && !in_stall;
    if (in_valid && !in_stall) hdrs_sent++;
  end

  // driver: offers queued headers with random gaps
  int gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_take) begin
        in_valid <= 1'b0;
        gap = $urandom_range(0, 8);
      end else if (!in_valid) begin
        if (gap > 0) gap--;
        else if (pending_hdrs.size() > 0) begin
          hdr_t h;
          h = pending_hdrs.pop_front();
          operation <= h.op; seq_in <= h.seq; stamp_seconds <= h.secs;
          stamp_fraction <= h.frac; read_stalled <= h.stl;
          in_valid <= 1'b1;
          expected_stats.push_back(predict_stats(h));
        end
      end
    end
  end

  // receiver stall: random waits plus occasional long hold-off
  int wait_cnt = 0;
  always @(negedge clk) begin
    if (hold_len > 0) begin
      hold_len--;
      out_stall <= 1'b1;
    end else if (wait_cnt > 0) begin
      wait_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && !out_stall) wait_cnt = $urandom_range(0, 8);
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    cycles++;
    if (!rst && out_valid && !out_stall) begin
      stats_t e;
      stats_seen++;
      if (expected_stats.size() == 0) begin
        errors++;
        $display("%0t unexpected result transfer", $time);
      end else begin
        e = expected_stats.pop_front();
        if (is_report) reports_seen++;
        if (is_report !== e.rep)
          $display("%0t is_report exp %0h got %0h", $time, e.rep, is_report);
        if (packet_total !== e.pkts)
          $display("%0t packet_total exp %0h got %0h", $time, e.pkts, packet_total);
        if (missed_total !== e.missed)
          $display("%0t missed_total exp %0h got %0h", $time, e.missed, missed_total);
        if (reorder_total !== e.reord)
          $display("%0t reorder_total exp %0h got %0h", $time, e.reord, reorder_total);
        if (bad_stamp_total !== e.bad)
          $display("%0t bad_stamp_total exp %0h got %0h", $time, e.bad, bad_stamp_total);
        if (starve_valid !== e.sv)
          $display("%0t starve_valid exp %0h got %0h", $time, e.sv, starve_valid);
        if (starve_seq !== e.sseq)
          $display("%0t starve_seq exp %0h got %0h", $time, e.sseq, starve_seq);
        if (is_report !== e.rep || packet_total !== e.pkts || missed_total !== e.missed
            || reorder_total !== e.reord || bad_stamp_total !== e.bad
            || starve_valid !== e.sv || starve_seq !== e.sseq)
          errors++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout, %0d results outstanding", $time, expected_stats.size());
      $display("** packet_loss_monitor_top: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CLOCK_TICKS:   m_ticks = val;
      REG_FRAME_SAMPLES: m_frame = val[7:0];
      REG_KEEP_LOWEST:   m_low = val[0];
      default:           m_window = val;
    endcase
  endtask

  task automatic drain_all();
    while (pending_hdrs.size() > 0 || in_valid || expected_stats.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic hdr_t make_hdr(logic op, logic [63:0] s, logic [31:0] sec,
                                    logic [31:0] fr, logic st);
    hdr_t h;
    h.op = op; h.seq = s; h.secs = sec; h.frac = fr; h.stl = st;
    return h;
  endfunction

  // random header: mostly a steady stream with small jitter, some noise
  logic [31:0] run_secs = 0, run_frac = 0;
  logic [63:0] run_seq = 1;
  function automatic hdr_t rand_hdr();
    hdr_t h;
    int k;
    k = $urandom_range(0, 99);
    h = make_hdr(OP_PACKET, run_seq, run_secs, run_frac, $urandom_range(0, 9) == 0);
    if (k < 6) h.op = OP_REPORT;
    else if (k < 12) h.secs = BAD_SECONDS;
    else if (k < 20) begin
      h.seq = {$urandom, $urandom};
      h.secs = $urandom; h.frac = $urandom;
    end else begin
      run_frac = run_frac + $urandom_range(0, 64);
      if ($urandom_range(0, 15) == 0) run_secs = run_secs + 1;
      run_seq = run_seq + $urandom_range(0, 4) - 1;
      if ($urandom_range(0, 30) == 0) run_seq = 64'hFFFF_FFFF_FFFF_FFF0;
      h.seq = run_seq; h.secs = run_secs;
      h.frac = run_frac - ($urandom_range(0, 3) == 0 ? $urandom_range(0, 100) : 0);
    end
    return h;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, stalls, bad stamps, reports, sequence zero
    pending_hdrs.push_back(make_hdr(OP_PACKET, 64'd0, 32'd0, 32'd0, 1'b1));
    pending_hdrs.push_back(make_hdr(OP_PACKET, 64'd5, 32'd1, 32'd100, 1'b1));
    pending_hdrs.push_back(make_hdr(OP_PACKET, 64'd7, 32'd1, 32'd116, 1'b0));
    pending_hdrs.push_back(make_hdr(OP_PACKET, 64'd3, 32'd1, 32'd50, 1'b0));
    pending_hdrs.push_back(make_hdr(OP_PACKET, 64'd20000, 32'd2, 32'd9000, 1'b0));
    pending_hdrs.push_back(make_hdr(OP_PACKET, '1, BAD_SECONDS, '1, 1'b1));
    pending_hdrs.push_back(make_hdr(OP_PACKET, '1, 32'hFFFF_FFFE, '1, 1'b0));
    pending_hdrs.push_back(make_hdr(OP_PACKET, 64'd1, 32'd0, 32'd0, 1'b0));
    pending_hdrs.push_back(make_hdr(OP_PACKET, 64'd0, 32'd3, 32'd0, 1'b1));
    pending_hdrs.push_back(make_hdr(OP_REPORT, '1, '1, '1, 1'b1));
    pending_hdrs.push_back(make_hdr(OP_REPORT, '0, '0, '0, 1'b0));
    drain_all();

    // directed with keep-lowest and extreme registers
    write_reg(REG_CLOCK_TICKS, '1);
    write_reg(REG_FRAME_SAMPLES, 32'd0);
    write_reg(REG_KEEP_LOWEST, 32'd1);
    write_reg(REG_ORDER_WINDOW, '1);
    pending_hdrs.push_back(make_hdr(OP_PACKET, 64'd100, '1 - 1, 32'd0, 1'b0));
    pending_hdrs.push_back(make_hdr(OP_PACKET, 64'd50, 32'd5, '1, 1'b0));
    pending_hdrs.push_back(make_hdr(OP_PACKET, 64'd60, 32'd4, 32'd0, 1'b0));
    pending_hdrs.push_back(make_hdr(OP_PACKET, 64'd9, 32'd4, 32'd0, 1'b1));
    pending_hdrs.push_back(make_hdr(OP_REPORT, 64'd0, 32'd0, 32'd0, 1'b0));
    drain_all();

    // random phases across several register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_CLOCK_TICKS, CLK_TICKS_RST);
                 write_reg(REG_FRAME_SAMPLES, 32'd16);
                 write_reg(REG_KEEP_LOWEST, 32'd0);
                 write_reg(REG_ORDER_WINDOW, WINDOW_RST); end
        1: begin write_reg(REG_FRAME_SAMPLES, 32'd255);
                 write_reg(REG_KEEP_LOWEST, 32'd1);
                 write_reg(REG_ORDER_WINDOW, 32'd3); end
        2: begin write_reg(REG_FRAME_SAMPLES, 32'd1);
                 write_reg(REG_CLOCK_TICKS, 32'd0);
                 write_reg(REG_ORDER_WINDOW, 32'd0); end
        3: begin write_reg(REG_CLOCK_TICKS, $urandom);
                 write_reg(REG_FRAME_SAMPLES, $urandom_range(1, 255));
                 write_reg(REG_KEEP_LOWEST, 32'd0);
                 write_reg(REG_ORDER_WINDOW, $urandom_range(1, 20)); end
        default: begin write_reg(REG_CLOCK_TICKS, 32'd48000 * 1024);
                 write_reg(REG_FRAME_SAMPLES, 32'd0);
                 write_reg(REG_KEEP_LOWEST, 32'd1);
                 write_reg(REG_ORDER_WINDOW, '1); end
      endcase
      for (int n = 0; n < 245; n++) pending_hdrs.push_back(rand_hdr());
      // long receiver hold-off while the sender keeps offering
      if (ph == 1) begin
        repeat (50) @(posedge clk);
        @(negedge clk);
        hold_len = 600;
      end
      drain_all();
    end

    $display("run covered %0d header transfers and %0d result transfers, %0d reports",
             hdrs_sent, stats_seen, reports_seen);
    if (errors == 0 && expected_stats.size() == 0) begin
      $display("** packet_loss_monitor_top: PASSED **");
    end else begin
      $display("** packet_loss_monitor_top: FAILED **");
    end
    $finish;
  end

endmodule
